>>> rtl/frp_pkg.sv
// Shared types, constants and the factorial weight table of the permutation rank unit.
package frp_pkg;

    localparam int ROW_NIBBLES   = 12;
    localparam int NIB_W         = 4;
    localparam int ROW_W         = ROW_NIBBLES * NIB_W;
    localparam int RANK_W        = 26;
    localparam int CFG_W         = 4;
    localparam int BELL_SLOTS    = 16;
    localparam int BELLS_W       = 5;
    localparam int MIN_BELLS     = 3;
    localparam int MAX_BELLS_DEF = 12;
    localparam logic [CFG_W-1:0] BELL_COUNT_RESET = 4'd8;

    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [RANK_W-1:0] t_rank;
    typedef logic [NIB_W-1:0]  t_nib;
    typedef logic [CFG_W-1:0]  t_cfg;
    typedef logic [BELLS_W-1:0] t_bells;
    typedef t_rank [BELL_SLOTS-1:0] t_weight_tbl;

    // Entry b holds (b-1)! modulo 2^RANK_W; entry 0 is never weighted and holds zero.
    function automatic t_weight_tbl weight_table();
        t_weight_tbl w;
        logic [63:0] f;
        w    = '0;
        f    = 64'd1;
        for (int b = 1; b < BELL_SLOTS; b++) begin
            w[b] = f[RANK_W-1:0];
            f    = f * 64'(b);
        end
        return w;
    endfunction

endpackage

>>> rtl/frp_if.sv
// Handshake channels of the permutation rank unit: row input, rank output, configuration.
interface frp_row_if;
    import frp_pkg::*;
    logic valid;
    logic ready;
    t_row row;
    modport source (output valid, output row, input ready);
    modport sink   (input valid, input row, output ready);
endinterface

interface frp_rank_if;
    import frp_pkg::*;
    logic  valid;
    logic  ready;
    t_rank rank;
    logic  row_invalid;
    modport source (output valid, output rank, output row_invalid, input ready);
    modport sink   (input valid, input rank, input row_invalid, output ready);
endinterface

interface frp_cfg_if;
    import frp_pkg::*;
    logic valid;
    logic ready;
    t_cfg bell_count;
    modport source (output valid, output bell_count, input ready);
    modport sink   (input valid, input bell_count, output ready);
endinterface

>>> rtl/frp_row_check.sv
// Permutation check of one row: bell 0 first and bells 0..n-1 each present once.
module frp_row_check #(
    parameter int MAX_BELLS = frp_pkg::MAX_BELLS_DEF
) (
    input  frp_pkg::t_nib [MAX_BELLS-1:0] i_bells,
    input  frp_pkg::t_bells               i_bell_n,
    output logic                          o_invalid
);
    import frp_pkg::*;

    logic [BELL_SLOTS-1:0] present;
    logic                  bad;

    // With n positions, each holding a bell below n, and every bell below n
    // present, no bell can appear twice.
    always_comb begin
        present = '0;
        bad     = (i_bells[0] != '0);
        for (int k = 0; k < MAX_BELLS; k++) begin
            if (BELLS_W'(k) < i_bell_n) begin
                if ({1'b0, i_bells[k]} >= i_bell_n) begin
                    bad = 1'b1;
                end
                present[i_bells[k]] = 1'b1;
            end
        end
        for (int b = 0; b < BELL_SLOTS; b++) begin
            if (BELLS_W'(b) < i_bell_n && !present[b]) begin
                bad = 1'b1;
            end
        end
        o_invalid = bad;
    end

endmodule

>>> rtl/fixed_first_permutation_rank_unit.sv
// Top level of the permutation rank unit: five-stage pipeline from row beat to rank beat.
//
// The unit ranks rows of bells in which bell 0 leads. A row beat carries up to twelve
// positions, four bits each; the configured bell count n (clamped to 3..MAX_BELLS)
// selects how many positions are used. The result beat carries the dense rank
// 0..(n-1)!-1 and a flag that is set, with rank 0, when bell 0 is not in position 0
// or the used positions are not a permutation of bells 0..n-1. The rank is built as a
// Lehmer code: for each position the number of later positions holding a lower bell,
// weighted by (bell-1)!. A row beat can be taken in every cycle while the output is not
// stalled, and its result passes through five register stages (comparison matrix and
// check, per-position counts, weighting multiplies, partial sums of four, final sum).
// Each stage holds its beat while the stage after it is full and stalled, so a stalled
// output fills the pipeline before the input ready drops. The bell count register is
// written through its own channel, which is always ready, and should only change while
// the pipeline is empty.
module fixed_first_permutation_rank_unit #(
    parameter int MAX_BELLS = frp_pkg::MAX_BELLS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    frp_cfg_if.sink         i_cfg,
    frp_row_if.sink         i_row,
    frp_rank_if.source      o_rank
);
    import frp_pkg::*;

    localparam int STAGES = 5;
    localparam int CNT_W  = $clog2(MAX_BELLS);
    localparam int GROUPS = (MAX_BELLS + 3) / 4;
    localparam t_weight_tbl WEIGHTS = weight_table();

    // Configuration register and the effective bell count.
    t_cfg   r_bell_count;
    t_bells bell_n;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bell_count <= BELL_COUNT_RESET;
        end else if (i_cfg.valid) begin
            r_bell_count <= i_cfg.bell_count;
        end
    end

    always_comb begin
        if ({1'b0, r_bell_count} < BELLS_W'(MIN_BELLS)) begin
            bell_n = BELLS_W'(MIN_BELLS);
        end else if ({1'b0, r_bell_count} > BELLS_W'(MAX_BELLS)) begin
            bell_n = BELLS_W'(MAX_BELLS);
        end else begin
            bell_n = {1'b0, r_bell_count};
        end
    end

    // Stage occupancy and the backward ready chain. A stage may load when it is
    // empty or when its beat moves on in the same cycle.
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] stg_rdy;

    always_comb begin
        stg_rdy[STAGES-1] = !r_vld[STAGES-1] || o_rank.ready;
        for (int s = STAGES - 2; s >= 0; s--) begin
            stg_rdy[s] = !r_vld[s] || stg_rdy[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[0]) begin
                r_vld[0] <= i_row.valid;
            end
            for (int s = 1; s < STAGES; s++) begin
                if (stg_rdy[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    assign i_row.ready = stg_rdy[0];

    // Stage 1: unpack the row, build the later-and-lower matrix, check the row.
    // Positions beyond the packed row read as bell 0.
    t_nib [MAX_BELLS-1:0]                  n_s1_bells;
    logic [MAX_BELLS-1:0][MAX_BELLS-1:0]   n_s1_lower;
    logic                                  n_s1_invalid;
    t_nib [MAX_BELLS-1:0]                  r_s1_bells;
    logic [MAX_BELLS-1:0][MAX_BELLS-1:0]   r_s1_lower;
    logic                                  r_s1_invalid;

    for (genvar k = 0; k < MAX_BELLS; k++) begin : g_unpack
        if (k < ROW_NIBBLES) begin : g_in_row
            assign n_s1_bells[k] = i_row.row[NIB_W*k +: NIB_W];
        end else begin : g_beyond
            assign n_s1_bells[k] = '0;
        end
    end

    always_comb begin
        n_s1_lower = '0;
        for (int p = 0; p < MAX_BELLS; p++) begin
            for (int q = 0; q < MAX_BELLS; q++) begin
                n_s1_lower[p][q] = (q > p) && (BELLS_W'(q) < bell_n)
                                   && (n_s1_bells[q] < n_s1_bells[p]);
            end
        end
    end

    frp_row_check #(
        .MAX_BELLS (MAX_BELLS)
    ) u_row_check (
        .i_bells   (n_s1_bells),
        .i_bell_n  (bell_n),
        .o_invalid (n_s1_invalid)
    );

    always_ff @(posedge i_clk) begin
        if (stg_rdy[0]) begin
            r_s1_bells   <= n_s1_bells;
            r_s1_lower   <= n_s1_lower;
            r_s1_invalid <= n_s1_invalid;
        end
    end

    // Stage 2: count, for each position, the later positions that hold a lower bell.
    logic [MAX_BELLS-1:0][CNT_W-1:0] n_s2_cnt;
    logic [MAX_BELLS-1:0][CNT_W-1:0] r_s2_cnt;
    t_nib [MAX_BELLS-1:0]            r_s2_bells;
    logic                            r_s2_invalid;

    always_comb begin
        for (int p = 0; p < MAX_BELLS; p++) begin
            n_s2_cnt[p] = '0;
            for (int q = 0; q < MAX_BELLS; q++) begin
                n_s2_cnt[p] = n_s2_cnt[p] + CNT_W'(r_s1_lower[p][q]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[1]) begin
            r_s2_cnt     <= n_s2_cnt;
            r_s2_bells   <= r_s1_bells;
            r_s2_invalid <= r_s1_invalid;
        end
    end

    // Stage 3: weight each count by (bell-1)!. An invalid row contributes nothing.
    t_rank [MAX_BELLS-1:0] n_s3_term;
    t_rank [MAX_BELLS-1:0] r_s3_term;
    logic                  r_s3_invalid;
    logic [CNT_W+RANK_W-1:0] prod [MAX_BELLS];

    always_comb begin
        for (int p = 0; p < MAX_BELLS; p++) begin
            prod[p] = r_s2_cnt[p] * WEIGHTS[r_s2_bells[p]];
            if (r_s2_invalid) begin
                n_s3_term[p] = '0;
            end else begin
                n_s3_term[p] = prod[p][RANK_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[2]) begin
            r_s3_term    <= n_s3_term;
            r_s3_invalid <= r_s2_invalid;
        end
    end

    // Stage 4: partial sums over groups of four positions, modulo 2^RANK_W.
    t_rank [GROUPS-1:0] n_s4_part;
    t_rank [GROUPS-1:0] r_s4_part;
    logic               r_s4_invalid;

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_s4_part[g] = '0;
            for (int e = 0; e < 4; e++) begin
                if (4 * g + e < MAX_BELLS) begin
                    n_s4_part[g] = n_s4_part[g] + r_s3_term[4*g+e];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[3]) begin
            r_s4_part    <= n_s4_part;
            r_s4_invalid <= r_s3_invalid;
        end
    end

    // Stage 5: final sum into the output register.
    t_rank n_s5_rank;
    t_rank r_s5_rank;
    logic  r_s5_invalid;

    always_comb begin
        n_s5_rank = '0;
        for (int g = 0; g < GROUPS; g++) begin
            n_s5_rank = n_s5_rank + r_s4_part[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[4]) begin
            r_s5_rank    <= n_s5_rank;
            r_s5_invalid <= r_s4_invalid;
        end
    end

    assign o_rank.valid       = r_vld[STAGES-1];
    assign o_rank.rank        = r_s5_rank;
    assign o_rank.row_invalid = r_s5_invalid;

`ifndef NO_ASSERTIONS
    a_invalid_rank_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rank.valid && o_rank.row_invalid |-> o_rank.rank == '0)
        else $error("flagged row carries a nonzero rank");

    a_bell_n_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bell_n >= BELLS_W'(MIN_BELLS) && bell_n <= BELLS_W'(MAX_BELLS))
        else $error("effective bell count outside its range");

    a_lead_bell_check : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && r_s1_bells[0] != '0 |-> r_s1_invalid)
        else $error("row without bell 0 leading was not flagged");

    a_stage_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] && !stg_rdy[3] |=> r_vld[2] && $stable(r_s3_term)
                                    && $stable(r_s3_invalid))
        else $error("stalled weighting stage lost or changed its beat");
`endif

endmodule
